FILE: sv/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin thread scheduler: request
// and result payloads, status codes, register map and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

    // configuration port
    localparam int unsigned REG_ADDR_W = 3;

    // register index, taken from paddr[REG_ADDR_W-1]
    typedef enum logic {
        REG_STACK_TOP  = 1'b0,
        REG_MAX_STACKS = 1'b1
    } t_reg;

    // request kinds
    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_YIELD  = 2'd1,
        REQ_START  = 2'd2
    } t_req;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [1:0] ST_NO_STACK  = 2'd2;
    localparam logic [1:0] ST_NO_THREAD = 2'd3;

    // exception frame
    localparam logic [3:0]  LAST_WORD   = 4'd15;
    localparam logic [31:0] XPSR_INIT   = 32'h0100_0000;
    localparam logic [31:0] FILL_WORD   = 32'h0000_000A;
    localparam logic [31:0] WORD_BYTES  = 32'd4;
    localparam logic [31:0] FRAME_BYTES = 32'd64;
    localparam logic [31:0] SAVE_OFFSET = 32'd32;

    // input item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] process_sp;
        logic [31:0] entry_addr;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [31:0] stack_pointer;
        logic        write_valid;
        logic [31:0] write_addr;
        logic [31:0] write_data;
        logic        last;
    } t_out_item;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SAVE,
        S_SCAN,
        S_FETCH,
        S_OFFSET,
        S_BASE,
        S_EMIT,
        S_RESULT
    } t_state;

    // single result of a failed request
    function automatic t_out_item fail_result(input logic [1:0] code);
        t_out_item r;
        r             = '0;
        r.status      = code;
        r.last        = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/round_robin_thread_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top
// Thread table with create, yield and start requests. Saved stack pointers
// live in a synchronous RAM; active flags and allocation count in flops.
// ----------------------------------------------------------------------------
// The slot walk checks one slot per cycle, up to THREAD_SLOTS slots.
// Create: the walk, then OFFSET and BASE, then sixteen frame words, one per
// cycle while the result channel is not stalled. Yield: SAVE, the walk and
// FETCH; start: the walk and FETCH; each to its single result.
// One request at a time; the next is taken while the last result waits.
// Reset (sync, active low): all slots inactive, current slot 0, no stacks
// allocated, stack_region_top 0, max_stacks 8. No clearing pass is needed.
`default_nettype none

module round_robin_thread_scheduler_top #(
    parameter int THREAD_SLOTS = 8,
    parameter int STACK_BYTES  = 1024
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // request channel
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  rrts_pkg::t_in_item                     i_in_data,
    // result channel
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output rrts_pkg::t_out_item                    o_out_data,
    // configuration port
    input  wire                                    psel,
    input  wire                                    penable,
    input  wire                                    pwrite,
    input  wire  [rrts_pkg::REG_ADDR_W-1:0]        paddr,
    input  wire  [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int          SLOT_W   = $clog2(THREAD_SLOTS);
    localparam int          CNT_W    = $clog2(THREAD_SLOTS + 1);
    localparam logic [31:0] STACK_SZ = 32'(STACK_BYTES);

    // state and registers
    rrts_pkg::t_state     r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    rrts_pkg::t_out_item  r_out, n_out;
    rrts_pkg::t_out_item  r_res, n_res;
    rrts_pkg::t_req       r_req, n_req;
    logic [31:0]          r_psp, n_psp;
    logic [31:0]          r_entry, n_entry;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [SLOT_W-1:0]    r_cur, n_cur;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [3:0]           r_alloc, n_alloc;
    logic [THREAD_SLOTS-1:0] r_active, n_active;
    logic [31:0]          r_offset, n_offset;
    logic [31:0]          r_waddr, n_waddr;
    logic [31:0]          r_sp, n_sp;
    logic [3:0]           r_k, n_k;
    logic [31:0]          r_stack_top;
    logic [3:0]           r_max_stacks;

    // stack pointer RAM control
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [31:0]          ram_wdata;
    logic [31:0]          ram_rdata;

    logic                 in_xfer;
    logic                 out_free;
    logic                 hit;
    logic                 no_stack;
    logic                 cfg_wr;
    logic [31:0]          frame_data;

    // next slot in round-robin order
    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] v);
        return (v == SLOT_W'(THREAD_SLOTS - 1)) ? '0 : v + 1'b1;
    endfunction

    // handshake
    assign o_in_stall  = (r_state != rrts_pkg::S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // slot walk test: create wants a free slot, yield and start an active one
    assign hit      = (r_req == rrts_pkg::REQ_CREATE) ? !r_active[r_idx] : r_active[r_idx];
    assign no_stack = (r_alloc >= r_max_stacks);

    // frame word contents
    always_comb begin
        case (r_k)
            4'd0:    frame_data = rrts_pkg::XPSR_INIT;
            4'd1:    frame_data = r_entry;
            default: frame_data = rrts_pkg::FILL_WORD;
        endcase
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_top  <= '0;
            r_max_stacks <= 4'd8;
        end else if (cfg_wr) begin
            case (rrts_pkg::t_reg'(paddr[rrts_pkg::REG_ADDR_W-1]))
                rrts_pkg::REG_STACK_TOP:  r_stack_top  <= pwdata;
                rrts_pkg::REG_MAX_STACKS: r_max_stacks <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (rrts_pkg::t_reg'(paddr[rrts_pkg::REG_ADDR_W-1]))
            rrts_pkg::REG_STACK_TOP:  prdata = r_stack_top;
            rrts_pkg::REG_MAX_STACKS: prdata = {28'd0, r_max_stacks};
            default:                  prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrts_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.req_type)
                        rrts_pkg::REQ_CREATE: n_state = rrts_pkg::S_SCAN;
                        rrts_pkg::REQ_START:  n_state = rrts_pkg::S_SCAN;
                        rrts_pkg::REQ_YIELD:  n_state = rrts_pkg::S_SAVE;
                        default:              n_state = rrts_pkg::S_IDLE;
                    endcase
                end
            end
            rrts_pkg::S_SAVE: n_state = rrts_pkg::S_SCAN;
            rrts_pkg::S_SCAN: begin
                if (hit) begin
                    if (r_req == rrts_pkg::REQ_CREATE) begin
                        n_state = no_stack ? rrts_pkg::S_RESULT : rrts_pkg::S_OFFSET;
                    end else begin
                        n_state = rrts_pkg::S_FETCH;
                    end
                end else if (r_cnt == CNT_W'(1)) begin
                    n_state = rrts_pkg::S_RESULT;
                end
            end
            rrts_pkg::S_FETCH:  n_state = rrts_pkg::S_RESULT;
            rrts_pkg::S_OFFSET: n_state = rrts_pkg::S_BASE;
            rrts_pkg::S_BASE:   n_state = rrts_pkg::S_EMIT;
            rrts_pkg::S_EMIT: begin
                if (out_free && r_k == rrts_pkg::LAST_WORD) begin
                    n_state = rrts_pkg::S_IDLE;
                end
            end
            rrts_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = rrts_pkg::S_IDLE;
                end
            end
            default: n_state = rrts_pkg::S_IDLE;
        endcase
    end

    // datapath and table updates per state
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_res       = r_res;
        n_req       = r_req;
        n_psp       = r_psp;
        n_entry     = r_entry;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_slot      = r_slot;
        n_alloc     = r_alloc;
        n_active    = r_active;
        n_offset    = r_offset;
        n_waddr     = r_waddr;
        n_sp        = r_sp;
        n_k         = r_k;
        ram_we      = 1'b0;
        ram_waddr   = r_cur;
        ram_wdata   = r_psp - rrts_pkg::SAVE_OFFSET;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rrts_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_req   = rrts_pkg::t_req'(i_in_data.req_type);
                    n_psp   = i_in_data.process_sp;
                    n_entry = i_in_data.entry_addr;
                    n_idx   = '0;
                    n_cnt   = CNT_W'(THREAD_SLOTS);
                end
            end
            // save the outgoing thread's pointer, walk starts after it
            rrts_pkg::S_SAVE: begin
                ram_we = r_active[r_cur];
                n_idx  = wrap_inc(r_cur);
            end
            rrts_pkg::S_SCAN: begin
                if (hit) begin
                    if (r_req == rrts_pkg::REQ_CREATE) begin
                        n_slot = r_idx;
                        n_res  = rrts_pkg::fail_result(rrts_pkg::ST_NO_STACK);
                    end else begin
                        n_cur = r_idx;
                    end
                end else begin
                    n_idx = wrap_inc(r_idx);
                    n_cnt = r_cnt - 1'b1;
                    n_res = rrts_pkg::fail_result((r_req == rrts_pkg::REQ_CREATE) ?
                                rrts_pkg::ST_NO_SLOT : rrts_pkg::ST_NO_THREAD);
                end
            end
            // saved pointer of the selected thread is back from the RAM
            rrts_pkg::S_FETCH: begin
                n_res               = '0;
                n_res.status        = rrts_pkg::ST_OK;
                n_res.slot          = 3'(r_cur);
                n_res.stack_pointer = ram_rdata;
                n_res.last          = 1'b1;
            end
            rrts_pkg::S_OFFSET: begin
                n_offset = STACK_SZ * ({28'd0, r_alloc} + 32'd1);
            end
            rrts_pkg::S_BASE: begin
                n_waddr = r_stack_top - r_offset - rrts_pkg::WORD_BYTES;
                n_sp    = r_stack_top - r_offset - rrts_pkg::FRAME_BYTES;
                n_k     = '0;
            end
            // one frame word transfer per cycle while the result channel is free, commit on the last
            rrts_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = rrts_pkg::ST_OK;
                    n_out.slot          = 3'(r_slot);
                    n_out.stack_pointer = r_sp;
                    n_out.write_valid   = 1'b1;
                    n_out.write_addr    = r_waddr;
                    n_out.write_data    = frame_data;
                    n_out.last          = (r_k == rrts_pkg::LAST_WORD);
                    n_waddr             = r_waddr - rrts_pkg::WORD_BYTES;
                    n_k                 = r_k + 1'b1;
                    if (r_k == rrts_pkg::LAST_WORD) begin
                        ram_we           = 1'b1;
                        ram_waddr        = r_slot;
                        ram_wdata        = r_sp;
                        n_active[r_slot] = 1'b1;
                        n_alloc          = r_alloc + 1'b1;
                    end
                end
            end
            rrts_pkg::S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrts_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_alloc     <= '0;
            r_active    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_alloc     <= n_alloc;
            r_active    <= n_active;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_res    <= n_res;
        r_req    <= n_req;
        r_psp    <= n_psp;
        r_entry  <= n_entry;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_slot   <= n_slot;
        r_offset <= n_offset;
        r_waddr  <= n_waddr;
        r_sp     <= n_sp;
        r_k      <= n_k;
    end

    // saved stack pointers, read at the walk position
    rrts_ram #(
        .WIDTH (32),
        .DEPTH (THREAD_SLOTS)
    ) u_sp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // checks
    a_write_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_valid |-> o_out_data.status == rrts_pkg::ST_OK)
        else $error("frame write carried with a failure status");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != rrts_pkg::ST_OK |->
            o_out_data.last && !o_out_data.write_valid)
        else $error("failed request result is not a lone final result");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rrts_pkg::S_SCAN |-> r_cnt != '0)
        else $error("slot walk ran past the table");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("scheduler went busy without a request transfer");

    a_commit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rrts_pkg::S_EMIT && out_free && r_k == rrts_pkg::LAST_WORD |=>
            r_active[$past(r_slot)])
        else $error("created thread not marked active");

endmodule

`default_nettype wire

FILE: sim/rrts_tb_pkg.sv
// ----------------------------------------------------------------------------
// rrts_tb_pkg
// Scoreboard for the round-robin thread scheduler bench: keeps a shadow of
// the thread table and the two registers, turns every accepted request into
// the results it must produce, and checks returned results in order.
// ----------------------------------------------------------------------------

package rrts_tb_pkg;

    import rrts_pkg::*;

    // block geometry, matching the instance in the bench
    localparam int          SLOTS       = 8;
    localparam int          STACK_SIZE  = 1024;
    localparam int          FRAME_WORDS = 16;
    localparam logic [31:0] XPSR_WORD   = 32'h0100_0000;
    localparam logic [31:0] FILL_VALUE  = 32'h0000_000A;
    localparam logic [31:0] SAVE_BYTES  = 32'd32;
    localparam logic [31:0] FRAME_SPAN  = 32'd64;

    // request code the block ignores
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;

    class thread_table_tracker;

        logic [31:0] region_top;
        logic [3:0]  stack_limit;
        logic [31:0] saved_sp [SLOTS];
        bit          active [SLOTS];
        int unsigned cur_slot;
        int unsigned stacks_used;
        t_out_item   pending_results [$];
        int unsigned errors;
        int unsigned requests;
        int unsigned results;
        int unsigned threads_made;

        function new();
            region_top   = '0;
            stack_limit  = 4'd8;
            cur_slot     = 0;
            stacks_used  = 0;
            errors       = 0;
            requests     = 0;
            results      = 0;
            threads_made = 0;
            foreach (saved_sp[i]) begin
                saved_sp[i] = '0;
                active[i]   = 1'b0;
            end
        endfunction

        // register write seen on the configuration port
        function void write_register(t_reg idx, logic [31:0] value);
            if (idx == REG_STACK_TOP)
                region_top = value;
            else
                stack_limit = value[3:0];
        endfunction

        // single result of a refused request
        function t_out_item status_only(logic [1:0] code);
            t_out_item r;
            r        = '0;
            r.status = code;
            r.last   = 1'b1;
            return r;
        endfunction

        // result of a yield or start that picked slot s
        function t_out_item pick_result(int unsigned s);
            t_out_item r;
            r               = '0;
            r.status        = ST_OK;
            r.slot          = 3'(s);
            r.stack_pointer = saved_sp[s];
            r.last          = 1'b1;
            return r;
        endfunction

        // advance the shadow table by one request and queue its results
        function void note_request(t_in_item req);
            int          free_slot;
            int unsigned cand;
            bit          found;
            logic [31:0] top;
            logic [31:0] sp;
            t_out_item   r;
            requests++;
            case (req.req_type)
                REQ_CREATE: begin
                    free_slot = -1;
                    for (int s = 0; s < SLOTS; s++)
                        if (!active[s] && free_slot < 0)
                            free_slot = s;
                    // free-slot test wins over stack-space test
                    if (free_slot < 0) begin
                        pending_results.push_back(status_only(ST_NO_SLOT));
                    end else if (stacks_used >= stack_limit) begin
                        pending_results.push_back(status_only(ST_NO_STACK));
                    end else begin
                        top = region_top - 32'(STACK_SIZE * (stacks_used + 1));
                        sp  = top - FRAME_SPAN;
                        for (int k = 0; k < FRAME_WORDS; k++) begin
                            r               = '0;
                            r.status        = ST_OK;
                            r.slot          = 3'(free_slot);
                            r.stack_pointer = sp;
                            r.write_valid   = 1'b1;
                            r.write_addr    = top - 32'(4 * (k + 1));
                            r.write_data    = (k == 0) ? XPSR_WORD :
                                              (k == 1) ? req.entry_addr : FILL_VALUE;
                            r.last          = (k == FRAME_WORDS - 1);
                            pending_results.push_back(r);
                        end
                        stacks_used         = (stacks_used + 1) % 16;
                        saved_sp[free_slot] = sp;
                        active[free_slot]   = 1'b1;
                        threads_made++;
                    end
                end
                REQ_YIELD: begin
                    // save even if no other thread is found
                    if (active[cur_slot])
                        saved_sp[cur_slot] = req.process_sp - SAVE_BYTES;
                    found = 1'b0;
                    for (int i = 1; i <= SLOTS; i++) begin
                        cand = (cur_slot + i) % SLOTS;
                        if (!found && active[cand]) begin
                            found    = 1'b1;
                            cur_slot = cand;
                            pending_results.push_back(pick_result(cand));
                        end
                    end
                    if (!found)
                        pending_results.push_back(status_only(ST_NO_THREAD));
                end
                REQ_START: begin
                    found = 1'b0;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (!found && active[s]) begin
                            found    = 1'b1;
                            cur_slot = s;
                            pending_results.push_back(pick_result(s));
                        end
                    end
                    if (!found)
                        pending_results.push_back(status_only(ST_NO_THREAD));
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got,
                                    time stamp);
            if (got !== want) begin
                errors++;
                $display("%0d ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                         stamp, name, want, got);
            end
        endfunction

        // compare one returned result with the oldest pending one
        function void check_result(t_out_item got, time stamp);
            t_out_item want;
            results++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0d ns: result with nothing pending, expected none, actual %h",
                         stamp, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status), stamp);
            compare_field("slot", 32'(want.slot), 32'(got.slot), stamp);
            compare_field("stack_pointer", want.stack_pointer, got.stack_pointer, stamp);
            compare_field("write_valid", 32'(want.write_valid), 32'(got.write_valid), stamp);
            compare_field("write_addr", want.write_addr, got.write_addr, stamp);
            compare_field("write_data", want.write_data, got.write_data, stamp);
            compare_field("last", 32'(want.last), 32'(got.last), stamp);
        endfunction

    endclass

endpackage

FILE: sim/round_robin_thread_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top_tb
// Drives create, yield and start requests through the thread scheduler, with
// register changes between phases and random gaps on both channels, and
// checks every result transfer against the scoreboard's shadow table.
// ----------------------------------------------------------------------------

module round_robin_thread_scheduler_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rrts_pkg::*;
    import rrts_tb_pkg::*;

    localparam int TAIL_CYCLES = SLOTS + 24;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // built before any process runs, so the stall driver can use it at time 0
    thread_table_tracker tracker = new();

    round_robin_thread_scheduler_top #(
        .THREAD_SLOTS (SLOTS),
        .STACK_BYTES  (STACK_SIZE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // idle mix: sender light / receiver heavy, then swapped, then none
    function automatic int sender_idle_pct();
        if (tracker.requests < 110)
            return 22;
        else if (tracker.requests < 220)
            return 62;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (tracker.requests < 110)
            return 62;
        else if (tracker.requests < 220)
            return 22;
        return 0;
    endfunction

    // receiver stall
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_out_data, $time);
    end

    function automatic t_in_item request(logic [1:0] kind, logic [31:0] psp,
                                         logic [31:0] entry);
        t_in_item r;
        r.req_type   = kind;
        r.process_sp = psp;
        r.entry_addr = entry;
        return r;
    endfunction

    // mostly yields, some creates and starts, a little ignored noise
    function automatic t_in_item random_request(int create_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return request(REQ_UNUSED, $urandom, $urandom);
        else if (pick < 5 + create_pct)
            return request(REQ_CREATE, $urandom, $urandom);
        else if (pick < 75)
            return request(REQ_YIELD, $urandom, $urandom);
        return request(REQ_START, $urandom, $urandom);
    endfunction

    // one request transfer, with random gaps ahead of it
    task automatic send_request(t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(item);
    endtask

    task automatic run_random(int count, int create_pct);
        repeat (count) send_request(random_request(create_pct));
    endtask

    // wait until every pending result is back, then let the block settle
    task automatic wait_drained();
        while (tracker.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // new register setting once the block has gone idle
    task automatic configure(logic [31:0] top, logic [3:0] limit);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
        apb_write(REG_STACK_TOP, top);
        apb_write(REG_MAX_STACKS, 32'(limit));
    endtask

    // run limit
    initial begin
        #5_000_000;
        $display("timeout with %0d results pending", tracker.pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, no stack budget
        configure(32'h0000_0000, 4'd0);
        send_request(request(REQ_START, 32'h0, 32'h0));
        send_request(request(REQ_YIELD, 32'hFFFF_FFFF, 32'h0));
        send_request(request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(request(REQ_CREATE, 32'h0, 32'hFFFF_FFFF));

        // one stack below address zero, so the frame wraps
        configure(32'h0000_0000, 4'd1);
        send_request(request(REQ_CREATE, 32'h0, 32'hFFFF_FFFF));
        send_request(request(REQ_CREATE, 32'hFFFF_FFFF, 32'h0));
        send_request(request(REQ_START, 32'h0, 32'h0));
        send_request(request(REQ_YIELD, 32'h0, 32'h0));
        send_request(request(REQ_YIELD, 32'hFFFF_FFFF, 32'h0));
        send_request(request(REQ_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // top of memory, full budget, two threads to alternate
        configure(32'hFFFF_FFFF, 4'd8);
        send_request(request(REQ_CREATE, 32'h0, 32'h0800_0001));
        send_request(request(REQ_YIELD, 32'h2000_0400, 32'h0));
        send_request(request(REQ_YIELD, 32'h5555_5555, 32'h0));
        send_request(request(REQ_YIELD, 32'hAAAA_AAAA, 32'h0));
        send_request(request(REQ_START, 32'h0, 32'h0));

        // random phases: budget grows until the table fills, then none left
        configure($urandom, 4'd3);
        run_random(75, 20);
        configure($urandom, 4'd6);
        run_random(75, 15);
        configure(32'h8000_0000, 4'd8);
        run_random(75, 15);
        configure(32'h0000_1000, 4'd0);
        run_random(70, 25);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();

        if (tracker.pending_results.size() != 0) begin
            tracker.errors++;
            $display("%0d expected results never arrived", tracker.pending_results.size());
        end
        $display("covered %0d requests and %0d result transfers, %0d threads created",
                 tracker.requests, tracker.results, tracker.threads_made);
        $display("stack budgets 0 to 8, region tops at both address extremes");
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
